// ----- hdl/teq_pkg.sv -----
// Shared types and constants for the timed event queue.
package teq_pkg;

  localparam int TimeBits   = 48;
  localparam int TagBits    = 16;
  localparam int IdBits     = 32;
  localparam int MaxResults = 32;

  typedef enum logic [2:0] {
    ACT_SCHEDULE = 3'd0,
    ACT_CANCEL   = 3'd1,
    ACT_CLEAR    = 3'd2,
    ACT_DELAY    = 3'd3,
    ACT_TAKE     = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    KIND_ID     = 3'd0,
    KIND_CANCEL = 3'd1,
    KIND_DUE    = 3'd2,
    KIND_NONE   = 3'd3,
    KIND_ACK    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_SCHED,
    OP_CANCEL,
    OP_CLEAR,
    OP_DELAY,
    OP_TAKE,
    OP_NOP
  } cmd_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [2:0]          action;
    logic [TimeBits-1:0] due_time;
    logic [TagBits-1:0]  payload_tag;
    logic [IdBits-1:0]   cancel_id;
    logic [TimeBits-1:0] delay_amount;
    logic [TimeBits-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          result_kind;
    logic [IdBits-1:0]   event_id;
    logic [TagBits-1:0]  event_tag;
    logic [TimeBits-1:0] event_time;
    logic                found;
    logic                full_error;
    logic [TimeBits-1:0] earliest_time;
    logic                queue_empty;
    logic                last;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    cmd_op_t             op;
    logic [TimeBits-1:0] time_arg;
    logic [TagBits-1:0]  tag;
    logic [IdBits-1:0]   id;
  } cmd_t;

endpackage

// ----- hdl/teq_front.sv -----
// Front stage: register and classify incoming requests.
module teq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  teq_pkg::in_item_t in_item,
  output logic              push,
  output teq_pkg::cmd_t     push_cmd,
  input  logic              fifo_full
);
  import teq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  cmd_t cmd_next;

  assign push     = cmd_valid && !fifo_full;
  assign in_stall = cmd_valid && fifo_full;
  assign push_cmd = cmd;

  // Pick the time operand that the action uses.
  always_comb begin
    cmd_next.tag = in_item.payload_tag;
    cmd_next.id  = in_item.cancel_id;
    case (in_item.action)
      ACT_SCHEDULE: begin
        cmd_next.op       = OP_SCHED;
        cmd_next.time_arg = in_item.due_time;
      end
      ACT_CANCEL: begin
        cmd_next.op       = OP_CANCEL;
        cmd_next.time_arg = in_item.due_time;
      end
      ACT_CLEAR: begin
        cmd_next.op       = OP_CLEAR;
        cmd_next.time_arg = in_item.due_time;
      end
      ACT_DELAY: begin
        cmd_next.op       = OP_DELAY;
        cmd_next.time_arg = in_item.delay_amount;
      end
      ACT_TAKE: begin
        cmd_next.op       = OP_TAKE;
        cmd_next.time_arg = in_item.now_time;
      end
      default: begin
        cmd_next.op       = OP_NOP;
        cmd_next.time_arg = in_item.due_time;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!in_stall) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ----- hdl/teq_fifo.sv -----
// Two-entry command queue between front and back.
module teq_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  teq_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          cmd_valid,
  output teq_pkg::cmd_t cmd
);
  import teq_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  assert property (@(posedge clk) disable iff (rst) pop |-> cmd_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
`endif

endmodule

// ----- hdl/teq_back.sv -----
// Back stage: sorted event store, executor and result register.
module teq_back #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  teq_pkg::cmd_t      cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output teq_pkg::out_item_t out_item
);
  import teq_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  logic [TimeBits-1:0] time_q [CAPACITY];
  logic [IdBits-1:0]   id_q   [CAPACITY];
  logic [TagBits-1:0]  tag_q  [CAPACITY];
  logic [TimeBits-1:0] time_next [CAPACITY];
  logic [IdBits-1:0]   id_next   [CAPACITY];
  logic [TagBits-1:0]  tag_next  [CAPACITY];
  logic [CntW-1:0]     count, count_next;
  logic [IdBits-1:0]   id_ctr, id_ctr_next;

  bk_state_t           state, state_next;
  logic [CntW-1:0]     take_left, take_left_next;
  logic [TimeBits-1:0] aft_time, aft_time_next;
  logic                aft_empty, aft_empty_next;

  out_item_t           res;
  logic                load;
  logic                out_free;

  logic [CAPACITY-1:0] valid_c, gt_due, id_hit, hit_pre, is_due;
  logic [TimeBits-1:0] sat_time [CAPACITY];
  logic [TimeBits:0]   sum      [CAPACITY];
  logic [CntW-1:0]     due_cnt, due_cap;

  assign out_free = !out_valid || !out_stall;

  // Per-entry compares and saturating adds, all in parallel.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_c[i]  = CntW'(i) < count;
      gt_due[i]   = valid_c[i] ? (time_q[i] > cmd.time_arg) : 1'b1;
      id_hit[i]   = valid_c[i] && (id_q[i] == cmd.id);
      is_due[i]   = valid_c[i] && (time_q[i] <= cmd.time_arg);
      sum[i]      = {1'b0, time_q[i]} + {1'b0, cmd.time_arg};
      sat_time[i] = sum[i][TimeBits] ? '1 : sum[i][TimeBits-1:0];
    end
    hit_pre[0] = id_hit[0];
    for (int i = 1; i < CAPACITY; i++) begin
      hit_pre[i] = hit_pre[i-1] || id_hit[i];
    end
    // Due entries form a prefix; count it by the first entry not due.
    due_cnt = CntW'(CAPACITY);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!is_due[i]) begin
        due_cnt = CntW'(i);
      end
    end
    due_cap = due_cnt;
    if (int'(due_cnt) > MaxResults) begin
      due_cap = CntW'(MaxResults);
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    id_ctr_next    = id_ctr;
    take_left_next = take_left;
    aft_time_next  = aft_time;
    aft_empty_next = aft_empty;
    pop            = 1'b0;
    load           = 1'b0;
    res            = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      time_next[i] = time_q[i];
      id_next[i]   = id_q[i];
      tag_next[i]  = tag_q[i];
    end
    res.last          = 1'b1;
    res.queue_empty   = (count == '0);
    res.earliest_time = (count == '0) ? '0 : time_q[0];

    case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          pop  = 1'b1;
          load = 1'b1;
          case (cmd.op)
            OP_SCHED: begin
              res.result_kind = KIND_ID;
              if (count == CntW'(CAPACITY)) begin
                res.full_error = 1'b1;
              end else begin
                res.event_id      = id_ctr;
                id_ctr_next       = id_ctr + 1'b1;
                count_next        = count + 1'b1;
                res.queue_empty   = 1'b0;
                res.earliest_time = gt_due[0] ? cmd.time_arg : time_q[0];
                // Insert ahead of the first later entry; shift the rest up.
                for (int i = 0; i < CAPACITY; i++) begin
                  if (gt_due[i]) begin
                    if (i == 0 || !gt_due[(i == 0) ? 0 : i-1]) begin
                      time_next[i] = cmd.time_arg;
                      id_next[i]   = id_ctr;
                      tag_next[i]  = cmd.tag;
                    end else begin
                      time_next[i] = time_q[(i == 0) ? 0 : i-1];
                      id_next[i]   = id_q[(i == 0) ? 0 : i-1];
                      tag_next[i]  = tag_q[(i == 0) ? 0 : i-1];
                    end
                  end
                end
              end
            end
            OP_CANCEL: begin
              res.result_kind = KIND_CANCEL;
              res.found       = hit_pre[CAPACITY-1];
              if (hit_pre[CAPACITY-1]) begin
                count_next        = count - 1'b1;
                res.queue_empty   = (count == CntW'(1));
                res.earliest_time = (count == CntW'(1)) ? '0 :
                                    (id_hit[0] ? time_q[1] : time_q[0]);
                // Close the gap left by the first match.
                for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (hit_pre[i]) begin
                    time_next[i] = time_q[i+1];
                    id_next[i]   = id_q[i+1];
                    tag_next[i]  = tag_q[i+1];
                  end
                end
              end
            end
            OP_CLEAR: begin
              res.result_kind   = KIND_ACK;
              count_next        = '0;
              res.queue_empty   = 1'b1;
              res.earliest_time = '0;
            end
            OP_DELAY: begin
              res.result_kind   = KIND_ACK;
              res.earliest_time = (count == '0) ? '0 : sat_time[0];
              for (int i = 0; i < CAPACITY; i++) begin
                time_next[i] = sat_time[i];
              end
            end
            OP_TAKE: begin
              if (due_cap == '0) begin
                res.result_kind = KIND_NONE;
              end else begin
                // Nothing leaves yet; work out the final state first.
                load           = 1'b0;
                take_left_next = due_cap;
                state_next     = BK_PREP;
              end
            end
            default: begin
              res.result_kind = KIND_ACK;
            end
          endcase
        end
      end
      BK_PREP: begin
        aft_empty_next = (take_left == count);
        aft_time_next  = (take_left == count) ? '0 : time_q[take_left[IdxW-1:0]];
        state_next     = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          load              = 1'b1;
          res.result_kind   = KIND_DUE;
          res.event_id      = id_q[0];
          res.event_tag     = tag_q[0];
          res.event_time    = time_q[0];
          res.earliest_time = aft_time;
          res.queue_empty   = aft_empty;
          res.last          = (take_left == CntW'(1));
          count_next        = count - 1'b1;
          take_left_next    = take_left - 1'b1;
          for (int i = 0; i < CAPACITY - 1; i++) begin
            time_next[i] = time_q[i+1];
            id_next[i]   = id_q[i+1];
            tag_next[i]  = tag_q[i+1];
          end
          if (take_left == CntW'(1)) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      id_ctr    <= '0;
      take_left <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      id_ctr    <= id_ctr_next;
      take_left <= take_left_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    aft_time  <= aft_time_next;
    aft_empty <= aft_empty_next;
    if (load) begin
      out_item <= res;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      time_q[i] <= time_next[i];
      id_q[i]   <= id_next[i];
      tag_q[i]  <= tag_next[i];
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) count <= CntW'(CAPACITY))
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT || state == BK_PREP) |-> (take_left != '0 && take_left <= count))
    else $error("release count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT && out_free) |=> (count == $past(count) - 1'b1))
    else $error("released event not removed");
`endif

endmodule

// ----- hdl/timed_event_queue.sv -----
// Top level of the timed event queue: front, command queue and back.
// A single-result request passes the front register, the queue and the back into
// the result register before it is on the outputs.
// Throughput: one single-result request per cycle while results are taken and the
// back is idle; take-due holds the back until all its released events are out.
// Reset clears the count, id counter and valid flags; entries are written before read.
module timed_event_queue #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  teq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output teq_pkg::out_item_t out_item
);
  import teq_pkg::*;

  // Front to queue.
  logic push;
  cmd_t push_cmd;
  logic fifo_full;

  // Queue to back.
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Register each request and resolve which time operand it carries.
  teq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  // Hold up to two requests so the front keeps accepting while the back
  // is busy releasing due events.
  teq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (q_pop),
    .cmd_valid (q_valid),
    .cmd       (q_cmd)
  );

  // Sorted store: insert, cancel and delay update all entries in parallel;
  // take-due drains the head one event per cycle while results are taken.
  teq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
